// File: sv/phase_quantise_bitpack_assert.svh
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef PHASE_QUANTISE_BITPACK_ASSERT_SVH
`define PHASE_QUANTISE_BITPACK_ASSERT_SVH

// property that must hold at every edge
`define PQB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PQB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pqb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqb_pkg;

  localparam int PHASE_W    = 17;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int SLOT_W     = 5;
  localparam int LEVEL_W    = 4;
  localparam int BITS_W     = 4;
  localparam int CHAN_W     = 2;
  localparam int OFF_W      = 3;
  localparam int ADDR_W     = 24;
  localparam int FW_W       = 11;
  localparam int LVL_W      = 16;
  localparam int NUM_LEVELS = 16;
  localparam int LANE_BITS  = 8;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int PLANES   = 24;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_DATA_W-1:0] LUT_RST     = '0;
  localparam logic [PHASE_W-1:0]    TOP_RST     = 17'h10000;
  localparam logic [CFG_DATA_W-1:0] PATTERN_RST = 64'hFEDC_BA98_7654_3210;
  localparam logic [FW_W-1:0]       FW_RST      = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LUT_0_3,
    CFG_LUT_4_7,
    CFG_LUT_8_11,
    CFG_LUT_12_15,
    CFG_LUT_TOP,
    CFG_PATTERN,
    CFG_FRAME_WIDTH
  } cfg_reg_e;

  // classified item handed from front to back
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CHAN_W-1:0]  chan;
    logic [OFF_W-1:0]   off;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } job_t;

endpackage

`default_nettype wire

// File: sv/pqb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pqb_in_if;
  logic                         valid;
  logic                         ready;
  logic [pqb_pkg::PHASE_W-1:0]  phase_sample;
  logic [pqb_pkg::COL_W-1:0]    cell_column;
  logic [pqb_pkg::ROW_W-1:0]    cell_row;
  logic [pqb_pkg::SLOT_W-1:0]   hologram_slot;

  modport source (
    output valid, phase_sample, cell_column, cell_row, hologram_slot,
    input  ready
  );
  modport sink (
    input  valid, phase_sample, cell_column, cell_row, hologram_slot,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/pqb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pqb_out_if;
  logic                         valid;
  logic                         ready;
  logic [pqb_pkg::LEVEL_W-1:0]  phase_level;
  logic [pqb_pkg::BITS_W-1:0]   mirror_bits;
  logic [pqb_pkg::CHAN_W-1:0]   color_channel;
  logic [pqb_pkg::OFF_W-1:0]    bit_offset;
  logic [pqb_pkg::ADDR_W-1:0]   block_address;

  modport source (
    output valid, phase_level, mirror_bits, color_channel, bit_offset, block_address,
    input  ready
  );
  modport sink (
    input  valid, phase_level, mirror_bits, color_channel, bit_offset, block_address,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/pqb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pqb_front (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  pqb_in_if.sink                                             in_i,
  input  wire logic [pqb_pkg::NUM_LEVELS-1:0][pqb_pkg::LVL_W-1:0] levels_i,
  input  wire logic [pqb_pkg::PHASE_W-1:0]                   level_top_i,
  output logic                                               push_valid_o,
  input  wire logic                                          push_ready_i,
  output pqb_pkg::job_t                                      push_data_o
);

  logic                        vld_q, vld_d;
  logic [pqb_pkg::PHASE_W-1:0] phase_q;
  logic [pqb_pkg::COL_W-1:0]   col_q;
  logic [pqb_pkg::ROW_W-1:0]   row_q;
  logic [pqb_pkg::SLOT_W-1:0]  slot_q;

  logic                        in_fire;

  // all 17 table points widened to the sample width
  logic [pqb_pkg::NUM_LEVELS:0][pqb_pkg::PHASE_W-1:0] pts;
  logic [pqb_pkg::NUM_LEVELS-1:0]                     hit;
  logic [pqb_pkg::NUM_LEVELS-1:0]                     upper;
  logic [pqb_pkg::LEVEL_W-1:0]                        level;

  logic [12:0]                 col_ext;
  logic [12:0]                 row_ext;
  logic [pqb_pkg::SLOT_W:0]    slot_ext;
  logic [pqb_pkg::SLOT_W-1:0]  slot_red;

  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = !vld_q || push_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (in_fire) begin
      vld_d = 1'b1;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      phase_q <= in_i.phase_sample;
      col_q   <= in_i.cell_column;
      row_q   <= in_i.cell_row;
      slot_q  <= in_i.hologram_slot;
    end
  end

  // per-interval hit and nearer-end decision, all in parallel
  always_comb begin
    for (int i = 0; i < pqb_pkg::NUM_LEVELS; i++) begin
      pts[i] = pqb_pkg::PHASE_W'(levels_i[i]);
    end
    pts[pqb_pkg::NUM_LEVELS] = level_top_i;
    for (int i = 0; i < pqb_pkg::NUM_LEVELS; i++) begin
      hit[i]   = (phase_q >= pts[i]) && (phase_q < pts[i+1]);
      upper[i] = (phase_q - pts[i]) >= (pts[i+1] - phase_q);
    end
  end

  // lowest interval wins; i+1 wraps to 0 at the top through truncation
  always_comb begin
    level = '0;
    for (int i = pqb_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        level = pqb_pkg::LEVEL_W'(i) + pqb_pkg::LEVEL_W'(upper[i]);
      end
    end
  end

  // inputs stay below twice each bound, so one compare and subtract reduces them
  always_comb begin
    col_ext = 13'(col_q);
    if (col_ext >= 13'(pqb_pkg::MAX_COLS)) begin
      col_ext = col_ext - 13'(pqb_pkg::MAX_COLS);
    end
    row_ext = 13'(row_q);
    if (row_ext >= 13'(pqb_pkg::MAX_ROWS)) begin
      row_ext = row_ext - 13'(pqb_pkg::MAX_ROWS);
    end
    slot_ext = (pqb_pkg::SLOT_W+1)'(slot_q);
    if (slot_ext >= (pqb_pkg::SLOT_W+1)'(pqb_pkg::PLANES)) begin
      slot_ext = slot_ext - (pqb_pkg::SLOT_W+1)'(pqb_pkg::PLANES);
    end
    slot_red = pqb_pkg::SLOT_W'(slot_ext);
  end

  assign push_valid_o      = vld_q;
  assign push_data_o.level = level;
  assign push_data_o.chan  = pqb_pkg::CHAN_W'(slot_red / pqb_pkg::LANE_BITS);
  assign push_data_o.off   = pqb_pkg::OFF_W'(slot_red % pqb_pkg::LANE_BITS);
  assign push_data_o.col   = pqb_pkg::COL_W'(col_ext);
  assign push_data_o.row   = pqb_pkg::ROW_W'(row_ext);

endmodule

`default_nettype wire

// File: sv/pqb_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "phase_quantise_bitpack_assert.svh"

module pqb_queue #(
  parameter int DEPTH = pqb_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire pqb_pkg::job_t push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output pqb_pkg::job_t      pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pqb_pkg::job_t     mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `PQB_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
  `PQB_ASSERT(a_empty_ptrs, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "empty queue with split pointers")
  `PQB_ASSERT_NEXT(a_cnt_up, push_fire && !pop_fire, cnt_q == $past(cnt_q) + CNT_W'(1), "count missed a push")
  `PQB_ASSERT_NEXT(a_cnt_down, pop_fire && !push_fire, cnt_q == $past(cnt_q) - CNT_W'(1), "count missed a pop")

endmodule

`default_nettype wire

// File: sv/pqb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pqb_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             pop_valid_i,
  output logic                                  pop_ready_o,
  input  wire pqb_pkg::job_t                    pop_data_i,
  input  wire logic [pqb_pkg::CFG_DATA_W-1:0]   pattern_i,
  input  wire logic [pqb_pkg::FW_W-1:0]         frame_width_i,
  pqb_out_if.source                             out_o
);

  localparam int PROD_W = pqb_pkg::ROW_W + pqb_pkg::FW_W;

  logic                         adv;
  logic                         s1_vld_q;
  logic [PROD_W-1:0]            s1_prod_q;
  logic [pqb_pkg::BITS_W-1:0]   s1_bits_q;
  pqb_pkg::job_t                s1_job_q;

  logic                         out_vld_q;
  logic [pqb_pkg::LEVEL_W-1:0]  out_level_q;
  logic [pqb_pkg::BITS_W-1:0]   out_bits_q;
  logic [pqb_pkg::CHAN_W-1:0]   out_chan_q;
  logic [pqb_pkg::OFF_W-1:0]    out_off_q;
  logic [pqb_pkg::ADDR_W-1:0]   out_addr_q;

  logic [pqb_pkg::ADDR_W:0]     addr_sum;

  // whole back pipeline moves together when the output slot frees up
  assign adv         = !out_vld_q || out_o.ready;
  assign pop_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= pop_valid_i;
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q <= PROD_W'(pop_data_i.row) * PROD_W'(frame_width_i);
      s1_bits_q <= pattern_i[{pop_data_i.level, 2'b00} +: pqb_pkg::BITS_W];
      s1_job_q  <= pop_data_i;
    end
  end

  // 16*r*width + 8*c + lane, kept to the low address bits
  assign addr_sum = {s1_prod_q, 4'b0000}
                  + (pqb_pkg::ADDR_W+1)'({s1_job_q.col, 3'b000})
                  + (pqb_pkg::ADDR_W+1)'(s1_job_q.chan);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_level_q <= s1_job_q.level;
      out_bits_q  <= s1_bits_q;
      out_chan_q  <= s1_job_q.chan;
      out_off_q   <= s1_job_q.off;
      out_addr_q  <= pqb_pkg::ADDR_W'(addr_sum);
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.phase_level   = out_level_q;
  assign out_o.mirror_bits   = out_bits_q;
  assign out_o.color_channel = out_chan_q;
  assign out_o.bit_offset    = out_off_q;
  assign out_o.block_address = out_addr_q;

endmodule

`default_nettype wire

// File: sv/phase_quantise_bitpack.sv
// with no stall, a sample passes the front input register, a queue slot, the row-times-width
// multiply register and the address add into the output register before the result is valid
// throughput: one sample per cycle; the back end stalls only on the output ready
// the two-entry queue lets the front keep accepting while the back end waits
// reset: queue and pipeline empty, table levels 0, top level one full wave,
// pattern binary counting, frame width 480
`timescale 1ns / 1ps
`default_nettype none

module phase_quantise_bitpack #(
  parameter int QUEUE_DEPTH = pqb_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pqb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pqb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  pqb_in_if.sink                               in_i,
  pqb_out_if.source                            out_o
);

  logic [3:0][pqb_pkg::CFG_DATA_W-1:0]  lut_q;
  logic [pqb_pkg::PHASE_W-1:0]          top_q;
  logic [pqb_pkg::CFG_DATA_W-1:0]       pattern_q;
  logic [pqb_pkg::FW_W-1:0]             fw_q;

  logic [pqb_pkg::NUM_LEVELS-1:0][pqb_pkg::LVL_W-1:0] levels;

  logic          push_valid;
  logic          push_ready;
  pqb_pkg::job_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  pqb_pkg::job_t pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_q     <= {4{pqb_pkg::LUT_RST}};
      top_q     <= pqb_pkg::TOP_RST;
      pattern_q <= pqb_pkg::PATTERN_RST;
      fw_q      <= pqb_pkg::FW_RST;
    end else if (cfg_we_i) begin
      unique case (pqb_pkg::cfg_reg_e'(cfg_idx_i))
        pqb_pkg::CFG_LUT_0_3:     lut_q[0]  <= cfg_data_i;
        pqb_pkg::CFG_LUT_4_7:     lut_q[1]  <= cfg_data_i;
        pqb_pkg::CFG_LUT_8_11:    lut_q[2]  <= cfg_data_i;
        pqb_pkg::CFG_LUT_12_15:   lut_q[3]  <= cfg_data_i;
        pqb_pkg::CFG_LUT_TOP:     top_q     <= pqb_pkg::PHASE_W'(cfg_data_i);
        pqb_pkg::CFG_PATTERN:     pattern_q <= cfg_data_i;
        pqb_pkg::CFG_FRAME_WIDTH: fw_q      <= pqb_pkg::FW_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // level k sits at bits 16k of the packed table words
  assign levels = {lut_q[3], lut_q[2], lut_q[1], lut_q[0]};

  pqb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .levels_i     (levels),
    .level_top_i  (top_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pqb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pqb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .pattern_i     (pattern_q),
    .frame_width_i (fw_q),
    .out_o         (out_o)
  );

endmodule

`default_nettype wire
